// ----- rtl/rwd_pkg.sv -----
`default_nettype none

package rwd_pkg;

  // Worker status codes
  localparam logic [1:0] StAvailable = 2'd0;
  localparam logic [1:0] StBusy      = 2'd1;
  localparam logic [1:0] StMaint     = 2'd2;

  // Request modes
  localparam logic [1:0] ModeAdd      = 2'd0;
  localparam logic [1:0] ModeAssign   = 2'd1;
  localparam logic [1:0] ModeComplete = 2'd2;
  localparam logic [1:0] ModeSet      = 2'd3;

  // Outcome codes
  localparam logic [2:0] OutOk       = 3'd0;
  localparam logic [2:0] OutFull     = 3'd1;
  localparam logic [2:0] OutEmpty    = 3'd2;
  localparam logic [2:0] OutNoneFree = 3'd3;
  localparam logic [2:0] OutNotFound = 3'd4;

  localparam logic [15:0] CountMax = 16'hFFFF;

  // One worker record as held in a cell
  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  status;
    logic [15:0] count;
    logic [31:0] task_tag;
    logic        has_task;
  } entry_t;

  // Per-cycle commands broadcast to every cell
  typedef struct packed {
    logic shift;  // rotate pool one place toward the head
    logic add;    // write new worker into the slot right after the tail
  } cell_ctrl_t;

  // Map status code three onto maintenance
  function automatic logic [1:0] clamp_status(input logic [1:0] s);
    return (s == 2'd3) ? StMaint : s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rwd_if.sv -----
`default_nettype none

interface rwd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] worker_id;
  logic [31:0] order_tag;
  logic [1:0]  new_status;

  modport source (output valid, mode, worker_id, order_tag, new_status, input ready);
  modport sink   (input valid, mode, worker_id, order_tag, new_status, output ready);
endinterface

interface rwd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic [15:0] chosen_worker;
  logic [15:0] chosen_count;

  modport source (output valid, outcome, chosen_worker, chosen_count, input ready);
  modport sink   (input valid, outcome, chosen_worker, chosen_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/rwd_cell.sv -----
`default_nettype none

module rwd_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned OccW = 5
) (
  input  wire logic                clk_i,
  input  wire rwd_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [OccW-1:0]     occ_i,
  input  wire rwd_pkg::entry_t     next_i,   // neighbor one place behind
  input  wire rwd_pkg::entry_t     wrap_i,   // updated head entry
  input  wire rwd_pkg::entry_t     new_i,    // worker being added
  output rwd_pkg::entry_t          entry_o
);

  rwd_pkg::entry_t entry_q, entry_d;
  logic            is_tail, is_free_slot;

  assign is_tail      = (occ_i == OccW'(Idx + 1));
  assign is_free_slot = (occ_i == OccW'(Idx));

  // Take the new worker, the wrapped head, or the neighbor's record; else hold
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.add && is_free_slot) begin
      entry_d = new_i;
    end else if (ctrl_i.shift) begin
      entry_d = is_tail ? wrap_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ----- rtl/rotating_worker_dispatcher_unit.sv -----
`default_nettype none

// Channel  Dir  Beat contents
// in_i     in   mode, worker_id, order_tag, new_status
// out_o    out  outcome, chosen_worker, chosen_count
//
// One request at a time. Add and any request on an empty pool go from accept
// straight to the result state; assign, complete and set status rotate the
// cell ring one place per cycle in the scan state first. Reset empties the
// pool; cell contents are left as they are.
// A stalled result beat parks the engine until out_o takes the previous one.

module rotating_worker_dispatcher_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rwd_in_if.sink    in_i,
  rwd_out_if.source out_o
);

  localparam int unsigned OccW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e                state_q;
  logic [OccW-1:0]       occ_q, step_q;
  logic [1:0]            mode_q;
  logic [15:0]           id_q;
  logic [31:0]           tag_q;
  logic [1:0]            nst_q;
  logic                  found_q;
  logic [2:0]            res_outcome_q;
  logic [15:0]           res_worker_q, res_count_q;
  logic                  out_valid_q;
  logic [2:0]            out_outcome_q;
  logic [15:0]           out_worker_q, out_count_q;

  rwd_pkg::entry_t       cells [DEPTH];
  rwd_pkg::entry_t       head, wrap, new_entry;
  rwd_pkg::cell_ctrl_t   ctrl;
  logic                  accept, out_free, pool_full, last_step, hit;
  logic [15:0]           inc_count;
  logic [OccW-1:0]       step_nx;

  assign accept    = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign pool_full = (occ_q == OccW'(DEPTH));
  assign step_nx   = step_q + 1'b1;
  assign last_step = (step_nx == occ_q);
  assign head      = cells[0];
  assign inc_count = (head.count == rwd_pkg::CountMax) ? head.count : head.count + 16'd1;

  // New worker record for add
  always_comb begin
    new_entry.id       = in_i.worker_id;
    new_entry.status   = rwd_pkg::clamp_status(in_i.new_status);
    new_entry.count    = '0;
    new_entry.task_tag = '0;
    new_entry.has_task = 1'b0;
  end

  // Decide whether the head matches and how it is rewritten on its way to the tail
  always_comb begin
    wrap = head;
    hit  = 1'b0;
    if (mode_q == rwd_pkg::ModeAssign) begin
      hit = (head.status == rwd_pkg::StAvailable);
      if (hit) begin
        wrap.status   = rwd_pkg::StBusy;
        wrap.count    = inc_count;
        wrap.task_tag = tag_q;
        wrap.has_task = 1'b1;
      end
    end else begin
      hit = (head.id == id_q) && !found_q;
      if (hit) begin
        if (mode_q == rwd_pkg::ModeComplete) begin
          wrap.status   = rwd_pkg::StAvailable;
          wrap.task_tag = '0;
          wrap.has_task = 1'b0;
        end else begin
          wrap.status = nst_q;
        end
      end
    end
  end

  assign ctrl.shift = (state_q == S_SCAN);
  assign ctrl.add   = accept && (in_i.mode == rwd_pkg::ModeAdd) && !pool_full;

  // Row of cells; the last one closes the ring
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    rwd_cell #(
      .Idx  (k),
      .OccW (OccW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .occ_i   (occ_q),
      .next_i  (cells[(k + 1) % DEPTH]),
      .wrap_i  (wrap),
      .new_i   (new_entry),
      .entry_o (cells[k])
    );
  end

  // Control, request capture, result and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      occ_q         <= '0;
      step_q        <= '0;
      mode_q        <= '0;
      id_q          <= '0;
      tag_q         <= '0;
      nst_q         <= '0;
      found_q       <= 1'b0;
      res_outcome_q <= '0;
      res_worker_q  <= '0;
      res_count_q   <= '0;
      out_valid_q   <= 1'b0;
      out_outcome_q <= '0;
      out_worker_q  <= '0;
      out_count_q   <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q        <= in_i.mode;
            id_q          <= in_i.worker_id;
            tag_q         <= in_i.order_tag;
            nst_q         <= rwd_pkg::clamp_status(in_i.new_status);
            step_q        <= '0;
            found_q       <= 1'b0;
            res_outcome_q <= rwd_pkg::OutOk;
            res_worker_q  <= '0;
            res_count_q   <= '0;
            state_q       <= S_RESULT;
            if (in_i.mode == rwd_pkg::ModeAdd) begin
              if (pool_full) begin
                res_outcome_q <= rwd_pkg::OutFull;
              end else begin
                occ_q <= occ_q + 1'b1;
              end
            end else if (occ_q == '0) begin
              res_outcome_q <= (in_i.mode == rwd_pkg::ModeAssign) ?
                               rwd_pkg::OutEmpty : rwd_pkg::OutNotFound;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          step_q <= step_nx;
          if (hit) begin
            found_q <= 1'b1;
          end
          if (mode_q == rwd_pkg::ModeAssign) begin
            // Stop as soon as a free worker has gone to the tail
            if (hit) begin
              res_worker_q <= head.id;
              res_count_q  <= inc_count;
              state_q      <= S_RESULT;
            end else if (last_step) begin
              res_outcome_q <= rwd_pkg::OutNoneFree;
              state_q       <= S_RESULT;
            end
          end else if (last_step) begin
            // Full turn done, pool order is back where it started
            if (!(hit || found_q)) begin
              res_outcome_q <= rwd_pkg::OutNotFound;
            end
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_outcome_q <= res_outcome_q;
            out_worker_q  <= res_worker_q;
            out_count_q   <= res_count_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.outcome       = out_outcome_q;
  assign out_o.chosen_worker = out_worker_q;
  assign out_o.chosen_count  = out_count_q;

endmodule

`default_nettype wire

// ----- sim/tb_rotating_worker_dispatcher_unit.sv -----
`timescale 1ns / 100ps

module tb_rotating_worker_dispatcher_unit;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int TASK_ROUNDS = 8;
  localparam int ITEMS_PER_PHASE = 375;
  localparam int PRESSURE_ITEMS = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 20;
  localparam logic [15:0] LEAD_ID = 16'h5A5A;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] worker_id;
    logic [31:0] order_tag;
    logic [1:0]  new_status;
  } dispatch_req_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [15:0] chosen_worker;
    logic [15:0] chosen_count;
  } dispatch_rsp_t;

  logic clk_i;
  logic rst_ni;

  rwd_in_if  req_if ();
  rwd_out_if rsp_if ();

  rotating_worker_dispatcher_unit #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Shadow copy of the worker pool
  rwd_pkg::entry_t  pool_q [DEPTH];
  logic [IDX_W-1:0] pool_head;
  logic [IDX_W:0]   pool_occ;

  dispatch_req_t request_q [$];
  dispatch_rsp_t pending_results [$];

  int unsigned beats_queued;
  int unsigned beats_accepted;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned outcome_hits [5];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_cnt;
  int unsigned stall_left;
  logic        hold_start;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [IDX_W-1:0] slot_at(input int unsigned pos);
    return IDX_W'((pool_head + pos) % DEPTH);
  endfunction

  // Move the head worker to the tail; occupancy is unchanged
  function automatic void rotate_head_to_tail();
    pool_q[slot_at(pool_occ)] = pool_q[pool_head];
    pool_head = IDX_W'((pool_head + 1) % DEPTH);
  endfunction

  // Apply one request to the shadow pool and return the result it yields
  function automatic dispatch_rsp_t predict_dispatch(input dispatch_req_t r);
    dispatch_rsp_t    res;
    logic [1:0]       st;
    logic [IDX_W-1:0] slot;
    int unsigned      n;
    int unsigned      i;
    int               pos;
    bit               done;
    res = '0;
    res.outcome = rwd_pkg::OutOk;
    // code three folds onto maintenance
    st = r.new_status[1] ? rwd_pkg::StMaint : r.new_status;
    case (r.mode)
      rwd_pkg::ModeAdd: begin
        if (pool_occ >= DEPTH) begin
          res.outcome = rwd_pkg::OutFull;
        end else begin
          slot = slot_at(pool_occ);
          pool_q[slot].id = r.worker_id;
          pool_q[slot].status = st;
          pool_q[slot].count = '0;
          pool_q[slot].task_tag = '0;
          pool_q[slot].has_task = 1'b0;
          pool_occ = pool_occ + 1'b1;
        end
      end
      rwd_pkg::ModeAssign: begin
        if (pool_occ == 0) begin
          res.outcome = rwd_pkg::OutEmpty;
        end else begin
          n = pool_occ;
          done = 1'b0;
          for (i = 0; i < n && !done; i++) begin
            slot = pool_head;
            if (pool_q[slot].status == rwd_pkg::StAvailable) begin
              pool_q[slot].status = rwd_pkg::StBusy;
              if (pool_q[slot].count != rwd_pkg::CountMax) begin
                pool_q[slot].count = pool_q[slot].count + 1'b1;
              end
              pool_q[slot].task_tag = r.order_tag;
              pool_q[slot].has_task = 1'b1;
              res.chosen_worker = pool_q[slot].id;
              res.chosen_count = pool_q[slot].count;
              done = 1'b1;
            end
            rotate_head_to_tail();
          end
          if (!done) begin
            res.outcome = rwd_pkg::OutNoneFree;
          end
        end
      end
      default: begin
        // first match from the head wins
        pos = -1;
        for (i = 0; i < pool_occ && pos < 0; i++) begin
          if (pool_q[slot_at(i)].id == r.worker_id) begin
            pos = i;
          end
        end
        if (pos < 0) begin
          res.outcome = rwd_pkg::OutNotFound;
        end else begin
          slot = slot_at(pos);
          if (r.mode == rwd_pkg::ModeComplete) begin
            pool_q[slot].status = rwd_pkg::StAvailable;
            pool_q[slot].task_tag = '0;
            pool_q[slot].has_task = 1'b0;
          end else begin
            pool_q[slot].status = st;
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] result %0d: %s got %0h want %0h", $time, results_seen, what, got, want);
    end
    mismatches++;
  endtask

  task automatic push_req(input logic [1:0] mode, input logic [15:0] id,
                          input logic [31:0] tag, input logic [1:0] st);
    dispatch_req_t r;
    r.mode = mode;
    r.worker_id = id;
    r.order_tag = tag;
    r.new_status = st;
    request_q.push_back(r);
    beats_queued++;
  endtask

  // Assigns, lookups on ids that are in the pool, some misses and adds
  task automatic queue_random_items(input int unsigned count);
    int unsigned sel;
    logic [15:0] known_id;
    for (int unsigned k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      known_id = (pool_occ == 0) ? 16'($urandom) :
                 pool_q[slot_at($urandom_range(pool_occ - 1))].id;
      if (sel < 35) begin
        push_req(rwd_pkg::ModeAssign, 16'($urandom), $urandom, 2'($urandom));
      end else if (sel < 63) begin
        push_req(rwd_pkg::ModeComplete, known_id, $urandom, 2'($urandom));
      end else if (sel < 82) begin
        push_req(rwd_pkg::ModeSet, known_id, $urandom, 2'($urandom));
      end else if (sel < 90) begin
        push_req(rwd_pkg::ModeAdd, 16'($urandom), $urandom, 2'($urandom));
      end else if (sel < 95) begin
        push_req(rwd_pkg::ModeComplete, 16'($urandom), $urandom, 2'($urandom));
      end else begin
        push_req(rwd_pkg::ModeSet, 16'($urandom), $urandom, 2'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (beats_accepted != beats_queued || pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned stall_pct,
                                  input int unsigned count);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    queue_random_items(count);
    wait_drained();
  endtask

  // Request driver: predict on each accepted beat, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    dispatch_req_t seen;
    dispatch_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.mode <= rwd_pkg::ModeAdd;
      req_if.worker_id <= '0;
      req_if.order_tag <= '0;
      req_if.new_status <= rwd_pkg::StAvailable;
      pool_head = '0;
      pool_occ = '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        seen.mode = req_if.mode;
        seen.worker_id = req_if.worker_id;
        seen.order_tag = req_if.order_tag;
        seen.new_status = req_if.new_status;
        pending_results.push_back(predict_dispatch(seen));
        beats_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.mode <= nxt.mode;
          req_if.worker_id <= nxt.worker_id;
          req_if.order_tag <= nxt.order_tag;
          req_if.new_status <= nxt.new_status;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    dispatch_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, outcome", rsp_if.outcome, 0);
        end else begin
          want = pending_results.pop_front();
          if (want.outcome <= rwd_pkg::OutNotFound) begin
            outcome_hits[want.outcome]++;
          end
          if (rsp_if.outcome !== want.outcome) begin
            report_mismatch("outcome", rsp_if.outcome, want.outcome);
          end
          if (rsp_if.chosen_worker !== want.chosen_worker) begin
            report_mismatch("chosen_worker", rsp_if.chosen_worker, want.chosen_worker);
          end
          if (rsp_if.chosen_count !== want.chosen_count) begin
            report_mismatch("chosen_count", rsp_if.chosen_count, want.chosen_count);
          end
        end
      end
      rsp_if.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long output hold-off, counted down on its own
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
    end else if (hold_start) begin
      stall_left <= HOLD_CYCLES;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Guard against a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    hold_start = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Requests on an empty pool
    push_req(rwd_pkg::ModeAssign, 16'h0000, 32'hFFFF_FFFF, rwd_pkg::StAvailable);
    push_req(rwd_pkg::ModeComplete, 16'h0000, 32'h0000_0000, rwd_pkg::StAvailable);
    push_req(rwd_pkg::ModeSet, 16'hFFFF, 32'h0000_0000, rwd_pkg::StBusy);
    wait_drained();

    // Bump one worker's task count over a few assign and complete rounds
    push_req(rwd_pkg::ModeAdd, LEAD_ID, 32'h0, rwd_pkg::StAvailable);
    for (int unsigned k = 0; k < TASK_ROUNDS; k++) begin
      push_req(rwd_pkg::ModeAssign, 16'($urandom), $urandom, 2'($urandom));
      push_req(rwd_pkg::ModeComplete, LEAD_ID, $urandom, 2'($urandom));
    end
    wait_drained();

    // Nobody free, status code three, duplicate ids, fill up, add to a full pool
    push_req(rwd_pkg::ModeSet, LEAD_ID, 32'h0, rwd_pkg::StBusy);
    push_req(rwd_pkg::ModeAssign, 16'h1234, 32'hDEAD_BEEF, rwd_pkg::StAvailable);
    push_req(rwd_pkg::ModeAdd, 16'h0000, 32'h0, 2'd3);
    push_req(rwd_pkg::ModeAdd, 16'hFFFF, 32'h0, rwd_pkg::StMaint);
    push_req(rwd_pkg::ModeAdd, 16'h0000, 32'h0, rwd_pkg::StAvailable);
    push_req(rwd_pkg::ModeSet, 16'h0000, 32'h0, rwd_pkg::StAvailable);
    push_req(rwd_pkg::ModeAssign, 16'h0000, 32'h0000_0000, rwd_pkg::StAvailable);
    push_req(rwd_pkg::ModeComplete, 16'h0000, 32'h0, rwd_pkg::StAvailable);
    push_req(rwd_pkg::ModeSet, 16'hFFFF, 32'h0, 2'd3);
    push_req(rwd_pkg::ModeComplete, 16'hFFFF, 32'h0, rwd_pkg::StAvailable);
    for (int unsigned k = 0; k < 12; k++) begin
      push_req(rwd_pkg::ModeAdd, 16'h8000 >> k, 32'h0, 2'(k));
    end
    push_req(rwd_pkg::ModeAdd, 16'hABCD, 32'h0, rwd_pkg::StAvailable);
    push_req(rwd_pkg::ModeAssign, 16'hFFFF, 32'hFFFF_FFFF, 2'd3);
    push_req(rwd_pkg::ModeAssign, 16'h0000, 32'h0000_0000, rwd_pkg::StAvailable);
    push_req(rwd_pkg::ModeComplete, 16'h7777, 32'h0, rwd_pkg::StAvailable);
    wait_drained();

    // Random traffic under different idle patterns
    run_random_phase(0, 0, ITEMS_PER_PHASE);
    run_random_phase(88, 0, ITEMS_PER_PHASE);
    run_random_phase(0, 88, ITEMS_PER_PHASE);
    run_random_phase(22, 22, ITEMS_PER_PHASE);

    // Hold the output off while requests keep coming, so the input backs up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    queue_random_items(PRESSURE_ITEMS);
    wait_drained();

    // Let any stray result surface
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests and %0d results over directed, idle and back-pressure phases",
             beats_accepted, results_seen);
    $display("outcomes: ok %0d, full %0d, empty %0d, none free %0d, not found %0d",
             outcome_hits[rwd_pkg::OutOk], outcome_hits[rwd_pkg::OutFull],
             outcome_hits[rwd_pkg::OutEmpty], outcome_hits[rwd_pkg::OutNoneFree],
             outcome_hits[rwd_pkg::OutNotFound]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
